// ===== hw/rtl/sclru_pkg.sv =====
// sclru_pkg: shared types and constants of the sector cache tag unit
// codes for modes and actions, cell control and chain structs
// no dependencies
package sclru_pkg;

  // fixed field widths
  localparam int SECTOR_W        = 48;
  localparam int MODE_W          = 3;
  localparam int ACT_W           = 3;
  localparam int SLOT_OUT_W      = 6;
  localparam int CNT_W           = 32;

  // defaults for the top level parameters
  localparam int DEF_SLOTS       = 16;
  localparam int DEF_SECTOR_BITS = 48;

  // request modes
  typedef enum logic [MODE_W-1:0] {
    MODE_READ       = 3'd0,
    MODE_WRITE      = 3'd1,
    MODE_FLUSH      = 3'd2,
    MODE_INV_ALL    = 3'd3,
    MODE_INV_SECTOR = 3'd4
  } mode_t;

  // result actions
  typedef enum logic [ACT_W-1:0] {
    ACT_HIT   = 3'd0,
    ACT_RMISS = 3'd1,
    ACT_WMISS = 3'd2,
    ACT_FLUSH = 3'd3,
    ACT_DONE  = 3'd4
  } act_t;

  // priority flags rippling from slot 0 upward
  typedef struct packed {
    logic hit;
    logic free;
    logic dirty;
  } chain_t;

  // per-cell lookup status
  typedef struct packed {
    logic match;
    logic hit_sel;
    logic free_sel;
    logic dirty_sel;
    logic oldest;
  } cell_sel_t;

  // broadcast update controls
  typedef struct packed {
    logic access;
    logic fill;
    logic dirty_val;
    logic drop;
    logic clean_first;
    logic clear_all;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/sclru_cell.sv =====
// sclru_cell: one cache slot with tag, valid, dirty and lru age
// uses sclru_pkg; chained to its neighbors through chain_t flags
module sclru_cell
  import sclru_pkg::*;
#(
  parameter int SLOTS = DEF_SLOTS,
  parameter int TAG_W = DEF_SECTOR_BITS,
  parameter int IDX   = 0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [TAG_W-1:0]           req_tag,
  input  cell_ctl_t                  ctl,
  input  logic [$clog2(SLOTS)-1:0]   tgt_slot,
  input  logic [$clog2(SLOTS)-1:0]   tgt_age,
  input  chain_t                     chain_in,
  output chain_t                     chain_out,
  output cell_sel_t                  sel,
  output logic                       valid,
  output logic                       dirty,
  output logic [$clog2(SLOTS)-1:0]   age,
  output logic [TAG_W-1:0]           tag
);

  localparam int AGE_W = $clog2(SLOTS);

  logic is_tgt;
  logic match;
  logic wb_dirty;

  // local lookup and priority ripple
  always_comb begin
    is_tgt   = (tgt_slot == AGE_W'(IDX));
    match    = valid && (tag == req_tag);
    wb_dirty = valid && dirty;

    sel.match     = match;
    sel.hit_sel   = match && !chain_in.hit;
    sel.free_sel  = !valid && !chain_in.free;
    sel.dirty_sel = wb_dirty && !chain_in.dirty;
    sel.oldest    = (age == AGE_W'(SLOTS - 1));

    chain_out.hit   = chain_in.hit || match;
    chain_out.free  = chain_in.free || !valid;
    chain_out.dirty = chain_in.dirty || wb_dirty;
  end

  // valid, dirty and age
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      dirty <= 1'b0;
      age   <= AGE_W'(IDX);
    end else if (ctl.clear_all) begin
      valid <= 1'b0;
      dirty <= 1'b0;
      age   <= AGE_W'(IDX);
    end else begin
      if (ctl.access) begin
        if (is_tgt) begin
          age <= '0;
          if (ctl.fill) begin
            valid <= 1'b1;
            dirty <= ctl.dirty_val;
          end else begin
            dirty <= dirty || ctl.dirty_val;
          end
        end else if (age < tgt_age) begin
          age <= age + AGE_W'(1);
        end
      end
      if (ctl.drop && is_tgt) begin
        valid <= 1'b0;
        dirty <= 1'b0;
      end
      if (ctl.clean_first && sel.dirty_sel) begin
        dirty <= 1'b0;
      end
    end
  end

  // tag store, written on a miss fill
  always_ff @(posedge clk) begin
    if (ctl.access && ctl.fill && is_tgt) begin
      tag <= req_tag;
    end
  end

endmodule

// ===== hw/rtl/sector_cache_lru_tags_unit.sv =====
// sector_cache_lru_tags_unit: tag and lru controller of a fully associative
// write-back sector cache
// uses sclru_pkg and a row of sclru_cell slots
//
// Usage:
//   input channel (in_valid/in_ready) carries mode and sector_number.
//   output channel (out_valid/out_ready) carries action, slot, write_back,
//   victim_sector, last and the read hit/miss totals.
//   read, write, invalidate sector and unused modes give one result with
//   last set; the parallel compare across the slot row is registered in the
//   lookup state, then the update state, once the output register is free,
//   does the age/valid/dirty update and writes the result there. A new item
//   is taken in the cycle its predecessor finishes, and not before.
//   flush and invalidate all give one writeback result per dirty slot, in
//   slot order, one per cycle while the receiver takes them, then a done
//   result with last set: the dirty slot row is walked by the priority chain.
//   reset empties every slot, puts ages in slot order, clears both totals
//   and drops any pending result; no clearing pass is needed.
//   when the receiver stalls the result waits in the output register; one
//   further input item is taken and looked up, then the unit waits.
module sector_cache_lru_tags_unit
  import sclru_pkg::*;
#(
  parameter int SLOTS       = DEF_SLOTS,
  parameter int SECTOR_BITS = DEF_SECTOR_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [MODE_W-1:0]     mode,
  input  logic [SECTOR_W-1:0]   sector_number,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ACT_W-1:0]      action,
  output logic [SLOT_OUT_W-1:0] slot,
  output logic                  write_back,
  output logic [SECTOR_W-1:0]   victim_sector,
  output logic                  last,
  output logic [CNT_W-1:0]      hit_total,
  output logic [CNT_W-1:0]      miss_total
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int TAG_W  = (SECTOR_BITS < SECTOR_W) ? SECTOR_BITS : SECTOR_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_UPDATE,
    S_FLUSH
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [MODE_W-1:0]   req_mode;
  logic [TAG_W-1:0]    req_tag;
  logic                lk_hit;
  logic [SLOT_W-1:0]   tgt_slot;
  logic [SLOT_W-1:0]   tgt_age;
  logic [CNT_W-1:0]    hit_cnt;
  logic [CNT_W-1:0]    miss_cnt;

  // cell row signals
  chain_t              chain [SLOTS+1];
  cell_sel_t           sel [SLOTS];
  cell_ctl_t           ctl;
  logic [SLOTS-1:0]    cell_valid;
  logic [SLOTS-1:0]    cell_dirty;
  logic [SLOT_W-1:0]   cell_age [SLOTS];
  logic [TAG_W-1:0]    cell_tag [SLOTS];
  logic [SLOTS-1:0]    match_vec;
  logic [SLOTS-1:0]    oldest_vec;

  // lookup results
  logic                hit_any;
  logic                free_any;
  logic                dirty_any;
  logic [SLOT_W-1:0]   hit_slot;
  logic [SLOT_W-1:0]   hit_age;
  logic [SLOT_W-1:0]   free_slot;
  logic [SLOT_W-1:0]   free_age;
  logic [SLOT_W-1:0]   old_slot;
  logic [SLOT_W-1:0]   fl_slot;
  logic [TAG_W-1:0]    fl_tag;

  // handshake and update control
  logic                out_free;
  logic                upd_fire;
  logic                fl_fire;
  logic                done_fire;
  logic                is_rw;
  logic                vic_wb;
  logic [ACT_W-1:0]    upd_action;
  logic [SLOT_W-1:0]   upd_slot;
  logic [CNT_W-1:0]    hit_next;
  logic [CNT_W-1:0]    miss_next;

  assign chain[0] = '0;

  // row of slot cells
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    sclru_cell #(
      .SLOTS (SLOTS),
      .TAG_W (TAG_W),
      .IDX   (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .req_tag   (req_tag),
      .ctl       (ctl),
      .tgt_slot  (tgt_slot),
      .tgt_age   (tgt_age),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1]),
      .sel       (sel[i]),
      .valid     (cell_valid[i]),
      .dirty     (cell_dirty[i]),
      .age       (cell_age[i]),
      .tag       (cell_tag[i])
    );
    assign match_vec[i]  = sel[i].match;
    assign oldest_vec[i] = sel[i].oldest;
  end

  assign hit_any   = chain[SLOTS].hit;
  assign free_any  = chain[SLOTS].free;
  assign dirty_any = chain[SLOTS].dirty;

  // encode the one-hot selections from the row
  always_comb begin
    hit_slot  = '0;
    hit_age   = '0;
    free_slot = '0;
    free_age  = '0;
    old_slot  = '0;
    fl_slot   = '0;
    fl_tag    = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (sel[i].hit_sel) begin
        hit_slot = hit_slot | SLOT_W'(i);
        hit_age  = hit_age | cell_age[i];
      end
      if (sel[i].free_sel) begin
        free_slot = free_slot | SLOT_W'(i);
        free_age  = free_age | cell_age[i];
      end
      if (sel[i].oldest) begin
        old_slot = old_slot | SLOT_W'(i);
      end
      if (sel[i].dirty_sel) begin
        fl_slot = fl_slot | SLOT_W'(i);
        fl_tag  = fl_tag | cell_tag[i];
      end
    end
  end

  // handshake
  always_comb begin
    out_free  = !out_valid || out_ready;
    upd_fire  = (state == S_UPDATE) && out_free;
    fl_fire   = (state == S_FLUSH) && out_free;
    done_fire = upd_fire || (fl_fire && !dirty_any);
    in_ready  = (state == S_IDLE) || done_fire;
  end

  // next controller state, a new transfer may start as the last one ends
  always_comb begin
    state_next = state;
    if (in_valid && in_ready) begin
      if ((mode == MODE_FLUSH) || (mode == MODE_INV_ALL)) begin
        state_next = S_FLUSH;
      end else begin
        state_next = S_LOOKUP;
      end
    end else if (state == S_LOOKUP) begin
      state_next = S_UPDATE;
    end else if (done_fire) begin
      state_next = S_IDLE;
    end
  end

  // update controls and result of a lookup item
  always_comb begin
    is_rw           = (req_mode == MODE_READ) || (req_mode == MODE_WRITE);
    ctl.access      = upd_fire && is_rw;
    ctl.fill        = upd_fire && is_rw && !lk_hit;
    ctl.dirty_val   = (req_mode == MODE_WRITE);
    ctl.drop        = upd_fire && (req_mode == MODE_INV_SECTOR) && lk_hit;
    ctl.clean_first = fl_fire && dirty_any;
    ctl.clear_all   = fl_fire && !dirty_any && (req_mode == MODE_INV_ALL);

    vic_wb = is_rw && !lk_hit && cell_valid[tgt_slot] && cell_dirty[tgt_slot];

    if (!is_rw) begin
      upd_action = ACT_DONE;
    end else if (lk_hit) begin
      upd_action = ACT_HIT;
    end else if (req_mode == MODE_WRITE) begin
      upd_action = ACT_WMISS;
    end else begin
      upd_action = ACT_RMISS;
    end

    if (is_rw || ((req_mode == MODE_INV_SECTOR) && lk_hit)) begin
      upd_slot = tgt_slot;
    end else begin
      upd_slot = '0;
    end

    hit_next  = hit_cnt;
    miss_next = miss_cnt;
    if (req_mode == MODE_READ) begin
      if (lk_hit) begin
        hit_next = hit_cnt + CNT_W'(1);
      end else begin
        miss_next = miss_cnt + CNT_W'(1);
      end
    end
  end

  // controller state, request, counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      hit_cnt   <= '0;
      miss_cnt  <= '0;
    end else begin
      // output valid: set on a new result, cleared once it is taken
      if (upd_fire || fl_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      state <= state_next;
      case (state)
        S_LOOKUP: begin
          lk_hit <= hit_any;
          if (hit_any) begin
            tgt_slot <= hit_slot;
            tgt_age  <= hit_age;
          end else if (free_any) begin
            tgt_slot <= free_slot;
            tgt_age  <= free_age;
          end else begin
            tgt_slot <= old_slot;
            tgt_age  <= SLOT_W'(SLOTS - 1);
          end
        end
        S_UPDATE: begin
          if (out_free) begin
            action        <= upd_action;
            slot          <= SLOT_OUT_W'(upd_slot);
            write_back    <= vic_wb;
            victim_sector <= vic_wb ? SECTOR_W'(cell_tag[tgt_slot]) : '0;
            last          <= 1'b1;
            hit_total     <= hit_next;
            miss_total    <= miss_next;
            hit_cnt       <= hit_next;
            miss_cnt      <= miss_next;
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            hit_total  <= hit_cnt;
            miss_total <= miss_cnt;
            if (dirty_any) begin
              action        <= ACT_FLUSH;
              slot          <= SLOT_OUT_W'(fl_slot);
              write_back    <= 1'b1;
              victim_sector <= SECTOR_W'(fl_tag);
              last          <= 1'b0;
            end else begin
              action        <= ACT_DONE;
              slot          <= '0;
              write_back    <= 1'b0;
              victim_sector <= '0;
              last          <= 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
      // input transfer, possibly in the cycle the previous item finishes
      if (in_valid && in_ready) begin
        req_mode <= mode;
        req_tag  <= sector_number[TAG_W-1:0];
      end
    end
  end

`ifndef SYNTHESIS
  // lru ages stay a permutation: exactly one slot is the oldest
  a_one_oldest: assert property (@(posedge clk) disable iff (rst)
    $onehot(oldest_vec))
    else $error("lru ages lost their permutation");

  // a sector is held by at most one valid slot
  a_unique_tag: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match_vec))
    else $error("sector present in more than one slot");

  // an input transfer always starts a lookup or a flush walk
  a_accept_next: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> (state == S_LOOKUP) || (state == S_FLUSH))
    else $error("input transfer did not start work");

  // flush results always carry a writeback and are never the last one
  a_flush_wb: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action == ACT_FLUSH) |-> write_back && !last)
    else $error("flush result without writeback");

  // a miss with a free slot never replaces a valid slot
  a_free_first: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOKUP) && !hit_any && free_any |=> !cell_valid[tgt_slot])
    else $error("valid slot chosen while a free slot exists");
`endif

endmodule

// ===== tb/sector_cache_lru_tags_unit_test.sv =====
`timescale 1ns / 100ps
// sector_cache_lru_tags_unit_test: self-checking bench for the sector cache tag unit
// directed and random requests checked against a behavioral slot store with lru ages
// depends on sclru_pkg and sector_cache_lru_tags_unit
module sector_cache_lru_tags_unit_test
  import sclru_pkg::*;
();

  localparam int SLOTS       = DEF_SLOTS;
  localparam int RANDOM_REQS = 393;
  localparam int POOL_SIZE   = 24;
  localparam int SETTLE_AT   = 250;
  localparam int PHASE_LEN   = 140;

  // modes the unit does not define
  localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

  typedef struct {
    logic [MODE_W-1:0]   mode;
    logic [SECTOR_W-1:0] sector;
  } cache_req_t;

  typedef struct {
    act_t                  action;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  write_back;
    logic [SECTOR_W-1:0]   victim;
    logic                  last;
    logic [CNT_W-1:0]      hits;
    logic [CNT_W-1:0]      misses;
  } cache_resp_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [MODE_W-1:0]     mode = '0;
  logic [SECTOR_W-1:0]   sector_number = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [ACT_W-1:0]      action;
  logic [SLOT_OUT_W-1:0] slot;
  logic                  write_back;
  logic [SECTOR_W-1:0]   victim_sector;
  logic                  last;
  logic [CNT_W-1:0]      hit_total;
  logic [CNT_W-1:0]      miss_total;

  sector_cache_lru_tags_unit dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .sector_number (sector_number),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .action        (action),
    .slot          (slot),
    .write_back    (write_back),
    .victim_sector (victim_sector),
    .last          (last),
    .hit_total     (hit_total),
    .miss_total    (miss_total)
  );

  always #6 clk = ~clk;

  // behavioral copy of the slot store
  logic [SECTOR_W-1:0] tag_m [SLOTS];
  bit                  valid_m [SLOTS];
  bit                  dirty_m [SLOTS];
  int                  age_m [SLOTS];
  logic [CNT_W-1:0]    hits_m;
  logic [CNT_W-1:0]    misses_m;

  cache_req_t          req_queue [$];
  cache_resp_t         results_due [$];
  logic [SECTOR_W-1:0] pool [POOL_SIZE];
  int                  items_taken = 0;
  int                  total_reqs = 0;
  int                  failures = 0;
  bit                  settle_done = 1'b0;

  function automatic void tags_reset();
    for (int i = 0; i < SLOTS; i++) begin
      tag_m[i]   = '0;
      valid_m[i] = 1'b0;
      dirty_m[i] = 1'b0;
      age_m[i]   = i;
    end
    hits_m   = '0;
    misses_m = '0;
  endfunction

  function automatic void push_result(act_t act, int s, logic wb,
                                      logic [SECTOR_W-1:0] victim, logic lst);
    cache_resp_t r;
    r.action     = act;
    r.slot       = SLOT_OUT_W'(s);
    r.write_back = wb;
    r.victim     = victim;
    r.last       = lst;
    r.hits       = hits_m;
    r.misses     = misses_m;
    results_due.push_back(r);
  endfunction

  function automatic int find_slot(logic [SECTOR_W-1:0] sec);
    for (int i = 0; i < SLOTS; i++)
      if (valid_m[i] && tag_m[i] == sec) return i;
    return -1;
  endfunction

  // move a slot to age 0, shift the younger ones up
  function automatic void touch_slot(int s);
    int a;
    a = age_m[s];
    for (int i = 0; i < SLOTS; i++)
      if (age_m[i] < a) age_m[i]++;
    age_m[s] = 0;
  endfunction

  // lowest free slot, else oldest with lowest index on ties
  function automatic int pick_victim();
    int best;
    best = 0;
    for (int i = 0; i < SLOTS; i++)
      if (!valid_m[i]) return i;
    for (int i = 1; i < SLOTS; i++)
      if (age_m[i] > age_m[best]) best = i;
    return best;
  endfunction

  // apply one request to the store and queue the results it gives
  function automatic void cache_predict(logic [MODE_W-1:0] req_mode,
                                        logic [SECTOR_W-1:0] sec);
    int s;
    logic wb;
    logic [SECTOR_W-1:0] victim;
    case (req_mode)
      MODE_READ, MODE_WRITE: begin
        s = find_slot(sec);
        if (s >= 0) begin
          if (req_mode == MODE_WRITE) dirty_m[s] = 1'b1;
          else hits_m++;
          touch_slot(s);
          push_result(ACT_HIT, s, 1'b0, '0, 1'b1);
        end else begin
          s = pick_victim();
          wb = valid_m[s] && dirty_m[s];
          victim = wb ? tag_m[s] : '0;
          if (req_mode == MODE_READ) misses_m++;
          tag_m[s]   = sec;
          valid_m[s] = 1'b1;
          dirty_m[s] = (req_mode == MODE_WRITE);
          touch_slot(s);
          if (req_mode == MODE_WRITE) push_result(ACT_WMISS, s, wb, victim, 1'b1);
          else push_result(ACT_RMISS, s, wb, victim, 1'b1);
        end
      end
      MODE_FLUSH, MODE_INV_ALL: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (valid_m[i] && dirty_m[i]) begin
            dirty_m[i] = 1'b0;
            push_result(ACT_FLUSH, i, 1'b1, tag_m[i], 1'b0);
          end
        end
        if (req_mode == MODE_INV_ALL) begin
          for (int i = 0; i < SLOTS; i++) begin
            valid_m[i] = 1'b0;
            dirty_m[i] = 1'b0;
            age_m[i]   = i;
          end
        end
        push_result(ACT_DONE, 0, 1'b0, '0, 1'b1);
      end
      MODE_INV_SECTOR: begin
        s = find_slot(sec);
        if (s >= 0) begin
          valid_m[s] = 1'b0;
          dirty_m[s] = 1'b0;
        end else begin
          s = 0;
        end
        push_result(ACT_DONE, s, 1'b0, '0, 1'b1);
      end
      default: push_result(ACT_DONE, 0, 1'b0, '0, 1'b1);
    endcase
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endfunction

  function automatic void queue_req(logic [MODE_W-1:0] m, logic [SECTOR_W-1:0] sec);
    cache_req_t r;
    r.mode   = m;
    r.sector = sec;
    req_queue.push_back(r);
  endfunction

  function automatic logic [SECTOR_W-1:0] random_sector();
    logic [63:0] wide;
    wide = {$urandom(), $urandom()};
    return wide[SECTOR_W-1:0];
  endfunction

  // request driver: predicts on each input transfer, then offers the next item
  always @(posedge clk) begin : driver
    int send_idle;
    bit hold;
    if (rst) begin
      in_valid <= 1'b0;
      tags_reset();
    end else begin
      if (in_valid && in_ready) begin
        cache_predict(mode, sector_number);
        items_taken++;
      end
      send_idle = (items_taken < PHASE_LEN) ? 34 : (items_taken < 2 * PHASE_LEN) ? 66 : 0;
      // one pause until the unit has answered everything
      if (!settle_done && items_taken >= SETTLE_AT && !in_valid && results_due.size() == 0)
        settle_done = 1'b1;
      hold = !settle_done && items_taken >= SETTLE_AT;
      if (!in_valid || in_ready) begin
        if (req_queue.size() != 0 && !hold && $urandom_range(99, 0) >= send_idle) begin
          in_valid      <= 1'b1;
          mode          <= req_queue[0].mode;
          sector_number <= req_queue[0].sector;
          void'(req_queue.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: compare each output transfer with the oldest prediction
  always @(posedge clk) begin : monitor
    cache_resp_t due;
    int recv_idle;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $error("unexpected result: action %0d slot %0d", action, slot);
          failures++;
        end else begin
          due = results_due.pop_front();
          check_field("action", due.action, action);
          check_field("slot", due.slot, slot);
          check_field("write_back", due.write_back, write_back);
          check_field("victim_sector", due.victim, victim_sector);
          check_field("last", due.last, last);
          check_field("hit_total", due.hits, hit_total);
          check_field("miss_total", due.misses, miss_total);
        end
      end
      recv_idle = (items_taken < PHASE_LEN) ? 66 : (items_taken < 2 * PHASE_LEN) ? 34 : 0;
      out_ready <= ($urandom_range(99, 0) >= recv_idle);
    end
  end

  // stimulus and end of run
  initial begin
    int pick;
    logic [MODE_W-1:0] m;
    logic [SECTOR_W-1:0] sec;

    pool[0] = '0;
    pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) pool[i] = random_sector();

    // directed: extremes, hits, misses, flushes, invalidates, spare modes
    queue_req(MODE_READ, '0);
    queue_req(MODE_READ, '0);
    queue_req(MODE_WRITE, '1);
    queue_req(MODE_WRITE, '0);
    queue_req(MODE_READ, '1);
    queue_req(MODE_FLUSH, '0);
    queue_req(MODE_FLUSH, '1);
    queue_req(MODE_WRITE, 48'h5555_5555_5555);
    queue_req(MODE_INV_SECTOR, '1);
    queue_req(MODE_INV_SECTOR, 48'h0000_0000_1234);
    queue_req(MODE_WRITE, 48'hAAAA_AAAA_AAAA);
    queue_req(MODE_SPARE_FIRST, random_sector());
    queue_req(MODE_SPARE_FIRST + 3'd1, random_sector());
    queue_req(MODE_SPARE_LAST, random_sector());
    queue_req(MODE_INV_ALL, '0);
    queue_req(MODE_READ, '1);
    queue_req(MODE_READ, '1);

    // random: mostly a small sector pool so the cache fills and evicts
    for (int n = 0; n < RANDOM_REQS; n++) begin
      pick = $urandom_range(99, 0);
      if (pick < 44) m = MODE_READ;
      else if (pick < 80) m = MODE_WRITE;
      else if (pick < 90) m = MODE_INV_SECTOR;
      else if (pick < 96) m = MODE_FLUSH;
      else if (pick < 98) m = MODE_INV_ALL;
      else m = MODE_W'($urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST));
      if ($urandom_range(9, 0) == 0) sec = random_sector();
      else sec = pool[$urandom_range(POOL_SIZE - 1, 0)];
      queue_req(m, sec);
    end
    total_reqs = req_queue.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (items_taken != total_reqs || results_due.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (results_due.size() != 0) begin
      $error("%0d expected results never arrived", results_due.size());
      failures++;
    end
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
